// ===== design/wavetable_oscillator_linear_interp_defines.svh =====
// assertion macros for the wavetable oscillator
// used by the top level only; expects clk and rst in scope
`ifndef WAVETABLE_OSCILLATOR_LINEAR_INTERP_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_LINEAR_INTERP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WOSC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wosc assertion failed");

// next-cycle implication, checked outside reset
`define WOSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wosc assertion failed");

`endif

// ===== design/wosc_pkg.sv =====
// shared constants for the wavetable oscillator
// no dependencies
package wosc_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_BITS   = 10;
  localparam int STEP_BITS   = 26;

  // request kinds carried on tuser
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

endpackage

// ===== design/wosc_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module wosc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/wosc_interp.sv =====
// interpolation pipeline: multiply stage, then add stage into the output register
// depends on wosc_pkg
module wosc_interp import wosc_pkg::*; #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_BITS-1:0]   lo_sample,
  input  logic [SAMPLE_BITS-1:0]   hi_sample,
  input  logic [FRACTION_BITS-1:0] frac,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SAMPLE_BITS-1:0]   out_sample
);

  localparam int PROD_BITS = SAMPLE_BITS + FRACTION_BITS + 2;

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [PROD_BITS-1:0]   prod_full;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [PROD_BITS-1:0]   prod_shr;
  logic [SAMPLE_BITS-1:0]        lo_q;
  logic                          mul_valid;
  logic                          out_en;
  logic                          mul_en;

  assign diff      = $signed({hi_sample[SAMPLE_BITS-1], hi_sample})
                   - $signed({lo_sample[SAMPLE_BITS-1], lo_sample});
  assign prod_full = diff * $signed({1'b0, frac});
  // arithmetic shift gives the floor of the scaled product
  assign prod_shr  = prod >>> FRACTION_BITS;

  assign out_en   = !out_valid || out_ready;
  assign mul_en   = !mul_valid || out_en;
  assign in_ready = mul_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mul_en) begin
        mul_valid <= in_valid;
      end
      if (out_en) begin
        out_valid <= mul_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en && in_valid) begin
      prod <= prod_full;
      lo_q <= lo_sample;
    end
    if (out_en && mul_valid) begin
      out_sample <= lo_q + prod_shr[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== design/wavetable_oscillator_linear_interp.sv =====
// Wavetable oscillator with linear interpolation between neighbouring entries.
//
// Input requests arrive on the s_ stream. s_tuser is the mode: a load request
// writes table_value into the table at table_address and gives no result; a
// tick request gives one interpolated sample on the m_ stream and then moves
// the phase on by phase_step, wrapping around the table (the entry after the
// last one is entry 0). phase_step is written through cfg_we/cfg_wdata.
//
// One request is taken every cycle while s_tready is high. On a tick the
// two table reads register at the edge that takes it (two copies of the
// table, one read port each), then the multiply registers, then the add
// into the output register, which makes the result valid on the m_ stream.
// Up to three ticks are in flight.
//
// Reset clears the phase, phase_step and the pipeline; table contents are
// undefined until loaded. When m_tready is low the output register holds and
// the pipeline keeps filling its empty stages; s_tready drops only once the
// table read stage is full and cannot move on.
module wavetable_oscillator_linear_interp import wosc_pkg::*; #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // table_address [9:0], table_value, zero padding
  input  logic [((ADDR_BITS+SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  // mode
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // sample_out, zero padding
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
  input  logic                 cfg_we,
  input  logic [STEP_BITS-1:0] cfg_wdata
);

`include "wavetable_oscillator_linear_interp_defines.svh"

  localparam int PHASE_BITS = ADDR_BITS + FRACTION_BITS;
  localparam int WIDE_BITS  = (PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS;
  localparam int OUT_W      = ((SAMPLE_BITS + 7) / 8) * 8;

  logic signed [STEP_BITS-1:0]  phase_step;
  logic signed [WIDE_BITS-1:0]  step_wide;
  logic [PHASE_BITS-1:0]        step_mod;
  logic [PHASE_BITS-1:0]        phase_acc;
  logic [ADDR_BITS-1:0]         addr_lo;
  logic [ADDR_BITS-1:0]         addr_hi;
  logic [FRACTION_BITS-1:0]     frac_q;
  logic [ADDR_BITS-1:0]         table_address;
  logic [SAMPLE_BITS-1:0]       table_value;
  logic                         accept;
  logic                         tick_acc;
  logic                         load_acc;
  logic                         rd_valid;
  logic                         rd_ready;
  logic [SAMPLE_BITS-1:0]       lo_sample;
  logic [SAMPLE_BITS-1:0]       hi_sample;
  logic [SAMPLE_BITS-1:0]       sample_out;

  assign table_address = s_tdata[ADDR_BITS-1:0];
  assign table_value   = s_tdata[ADDR_BITS +: SAMPLE_BITS];

  assign accept   = s_tvalid && s_tready;
  assign tick_acc = accept && (s_tuser == MODE_TICK);
  assign load_acc = accept && (s_tuser == MODE_LOAD);
  assign s_tready = !rd_valid || rd_ready;

  // the period is a power of two, so the wrap is just truncation
  assign step_wide = WIDE_BITS'(phase_step);
  assign step_mod  = step_wide[PHASE_BITS-1:0];

  assign addr_lo = phase_acc[PHASE_BITS-1:FRACTION_BITS];
  assign addr_hi = addr_lo + ADDR_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      phase_acc  <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        phase_step <= cfg_wdata;
      end
      if (tick_acc) begin
        phase_acc <= phase_acc + step_mod;
      end
      if (s_tready) begin
        rd_valid <= tick_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      frac_q <= phase_acc[FRACTION_BITS-1:0];
    end
  end

  // two copies of the table so both neighbours are read in the same cycle
  wosc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_ram_lo (
    .clk   (clk),
    .we    (load_acc),
    .waddr (table_address),
    .wdata (table_value),
    .re    (tick_acc),
    .raddr (addr_lo),
    .rdata (lo_sample)
  );

  wosc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_ram_hi (
    .clk   (clk),
    .we    (load_acc),
    .waddr (table_address),
    .wdata (table_value),
    .re    (tick_acc),
    .raddr (addr_hi),
    .rdata (hi_sample)
  );

  wosc_interp #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_interp (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rd_valid),
    .in_ready   (rd_ready),
    .lo_sample  (lo_sample),
    .hi_sample  (hi_sample),
    .frac       (frac_q),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sample (sample_out)
  );

  assign m_tdata = OUT_W'(sample_out);

  `WOSC_ASSERT_NEXT(a_tick_advances_phase, tick_acc, phase_acc == $past(phase_acc + step_mod))
  `WOSC_ASSERT_NEXT(a_load_keeps_phase, load_acc, $stable(phase_acc))
  `WOSC_ASSERT_NEXT(a_tick_fills_read_stage, tick_acc, rd_valid)
  `WOSC_ASSERT_IMPLY(a_stalled_read_blocks_input, rd_valid && !rd_ready, !s_tready)

endmodule
